>>> rtl/core/assert_macros.svh
// Assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define CHK_ALWAYS(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define CHK_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_ALWAYS(name, clk, rst_n, cond, msg)
`define CHK_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/ptfv_pkg.sv
package ptfv_pkg;

  localparam int VCOUNT      = 4;
  localparam int VCOUNT_LOG2 = 2;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_SHIFT  = 2'd1;
  localparam logic [1:0] CMD_ROTATE = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic signed [17:0] MAT_ONE     = 18'sd65536;
  localparam logic signed [21:0] ANG_PI      = 22'sd205887;
  localparam logic signed [21:0] ANG_HALF_PI = 22'sd102944;
  localparam logic signed [21:0] ANG_TWO_PI  = 22'sd411775;
  localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;
  localparam logic [3:0]         CORDIC_LAST = 4'd15;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_LOAD    = 10'b0000000010,
    S_CENT    = 10'b0000000100,
    S_SHIFT   = 10'b0000001000,
    S_CINIT   = 10'b0000010000,
    S_CSTEP   = 10'b0000100000,
    S_CFIN    = 10'b0001000000,
    S_MAT     = 10'b0010000000,
    S_MCOMMIT = 10'b0100000000,
    S_EMIT    = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       load_wr;
    logic       cent_upd;
    logic       shift_upd;
    logic       cordic_init;
    logic       cordic_step;
    logic       cordic_fin;
    logic       mac_issue;
    logic       mac_first;
    logic       mat_mode;
    logic       mat_wr;
    logic       mat_commit;
    logic       vert_wr;
    logic [3:0] cstep;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] k;
    logic [1:0] v;
  } ctl_t;

  function automatic logic signed [21:0] atan_val(input logic [3:0] n);
    logic signed [21:0] r;
    case (n)
      4'd0:    r = 22'sd51472;
      4'd1:    r = 22'sd30385;
      4'd2:    r = 22'sd16055;
      4'd3:    r = 22'sd8150;
      4'd4:    r = 22'sd4091;
      4'd5:    r = 22'sd2047;
      4'd6:    r = 22'sd1024;
      4'd7:    r = 22'sd512;
      4'd8:    r = 22'sd256;
      4'd9:    r = 22'sd128;
      4'd10:   r = 22'sd64;
      4'd11:   r = 22'sd32;
      4'd12:   r = 22'sd16;
      4'd13:   r = 22'sd8;
      4'd14:   r = 22'sd4;
      default: r = 22'sd2;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > 41'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -41'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [17:0] clamp18(input logic signed [40:0] v);
    logic signed [17:0] r;
    if (v > 41'sd131071)       r = 18'sd131071;
    else if (v < -41'sd131072) r = -18'sd131072;
    else                       r = v[17:0];
    return r;
  endfunction

  // Entry (i,k) of the axis rotation that premultiplies the pose
  function automatic logic signed [18:0] amat(input logic [1:0] axis,
                                              input logic signed [17:0] s,
                                              input logic signed [17:0] c,
                                              input logic [1:0] i,
                                              input logic [1:0] k);
    logic signed [18:0] cs, ps, ns, r;
    cs = 19'(c);
    ps = 19'(s);
    ns = -ps;
    r  = (i == k) ? 19'(MAT_ONE) : 19'sd0;
    case (axis)
      AXIS_X: begin
        if (i == 2'd1 && k == 2'd1) r = cs;
        if (i == 2'd1 && k == 2'd2) r = ns;
        if (i == 2'd2 && k == 2'd1) r = ps;
        if (i == 2'd2 && k == 2'd2) r = cs;
      end
      AXIS_Y: begin
        if (i == 2'd0 && k == 2'd0) r = cs;
        if (i == 2'd0 && k == 2'd2) r = ps;
        if (i == 2'd2 && k == 2'd0) r = ns;
        if (i == 2'd2 && k == 2'd2) r = cs;
      end
      AXIS_Z: begin
        if (i == 2'd0 && k == 2'd0) r = cs;
        if (i == 2'd0 && k == 2'd1) r = ns;
        if (i == 2'd1 && k == 2'd0) r = ps;
        if (i == 2'd1 && k == 2'd1) r = cs;
      end
      default: r = r;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/ptfv_ctrl.sv
module ptfv_ctrl
  import ptfv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_cmd,
  input  logic [1:0] in_axis,
  output logic       busy,
  output ctl_t       ctl
);

  state_t     state_r, state_nxt;
  logic [3:0] cstep_r, cstep_nxt;
  logic [2:0] k_r, k_nxt;
  logic [1:0] i_r, i_nxt, j_r, j_nxt, v_r, v_nxt;
  logic       accept;
  logic       dot_end;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign dot_end = (k_r == 3'd4);

  always_comb begin
    state_nxt = state_r;
    cstep_nxt = cstep_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    v_nxt     = v_r;
    case (state_r)
      S_IDLE: begin
        cstep_nxt = '0;
        k_nxt     = '0;
        i_nxt     = '0;
        j_nxt     = '0;
        v_nxt     = '0;
        if (accept) begin
          case (in_cmd)
            CMD_LOAD:   state_nxt = S_LOAD;
            CMD_SHIFT:  state_nxt = S_SHIFT;
            CMD_ROTATE: state_nxt = (in_axis == AXIS_NONE) ? S_EMIT : S_CINIT;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD:  state_nxt = S_CENT;
      S_CENT:  state_nxt = S_IDLE;
      S_SHIFT: state_nxt = S_EMIT;
      S_CINIT: state_nxt = S_CSTEP;
      S_CSTEP: begin
        cstep_nxt = cstep_r + 4'd1;
        if (cstep_r == CORDIC_LAST) state_nxt = S_CFIN;
      end
      S_CFIN: state_nxt = S_MAT;
      S_MAT: begin
        k_nxt = k_r + 3'd1;
        if (dot_end) begin
          k_nxt = '0;
          j_nxt = j_r + 2'd1;
          if (j_r == 2'd2) begin
            j_nxt = '0;
            i_nxt = i_r + 2'd1;
            if (i_r == 2'd2) begin
              i_nxt     = '0;
              state_nxt = S_MCOMMIT;
            end
          end
        end
      end
      S_MCOMMIT: state_nxt = S_EMIT;
      S_EMIT: begin
        k_nxt = k_r + 3'd1;
        if (dot_end) begin
          k_nxt = '0;
          i_nxt = i_r + 2'd1;
          if (i_r == 2'd2) begin
            i_nxt = '0;
            v_nxt = v_r + 2'd1;
            if (v_r == 2'(VCOUNT - 1)) state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cstep_r <= '0;
      k_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      v_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cstep_r <= cstep_nxt;
      k_r     <= k_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      v_r     <= v_nxt;
    end
  end

  always_comb begin
    ctl             = '0;
    ctl.capture     = accept;
    ctl.load_wr     = (state_r == S_LOAD);
    ctl.cent_upd    = (state_r == S_CENT);
    ctl.shift_upd   = (state_r == S_SHIFT);
    ctl.cordic_init = (state_r == S_CINIT);
    ctl.cordic_step = (state_r == S_CSTEP);
    ctl.cordic_fin  = (state_r == S_CFIN);
    ctl.mat_mode    = (state_r == S_MAT);
    ctl.mac_issue   = ((state_r == S_MAT) || (state_r == S_EMIT)) && (k_r < 3'd3);
    ctl.mac_first   = (k_r == 3'd0);
    ctl.mat_wr      = (state_r == S_MAT) && dot_end;
    ctl.mat_commit  = (state_r == S_MCOMMIT);
    ctl.vert_wr     = (state_r == S_EMIT) && dot_end;
    ctl.cstep       = cstep_r;
    ctl.i           = i_r;
    ctl.j           = j_r;
    ctl.k           = k_r[1:0];
    ctl.v           = v_r;
  end

endmodule

>>> rtl/core/ptfv_dp.sv
module ptfv_dp
  import ptfv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_t               ctl,
  input  logic [1:0]         in_axis,
  input  logic [1:0]         in_vertex_index,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [31:0] in_amount,
  input  logic signed [15:0] in_angle,
  output logic               out_valid,
  output logic [1:0]         out_index,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_last_vertex
);

  logic [1:0]         axis_r, idx_r;
  logic signed [31:0] px_r, py_r, pz_r, amt_r;
  logic signed [15:0] ang_r;

  logic signed [31:0] vtx_r [VCOUNT][3];
  logic signed [31:0] cent_r [3];
  logic signed [31:0] off_r [3];
  logic signed [17:0] rot_r [3][3];
  logic signed [17:0] rnew_r [3][3];

  logic signed [19:0] x_r, y_r;
  logic signed [21:0] z_r;
  logic               neg_r;
  logic signed [17:0] s_r, c_r;

  logic signed [18:0] a_r;
  logic signed [33:0] b_r;
  logic               mac_v_r, first_r;
  logic signed [55:0] acc_r;

  logic               valid_r, last_r;
  logic [1:0]         index_r;
  logic signed [31:0] ox_r, oy_r, oz_r;

  // angle range reduction
  logic signed [21:0] z0, z1, z2;
  logic               neg0;
  always_comb begin
    z0   = 22'(ang_r) <<< 4;
    z1   = z0;
    if (z0 > ANG_PI)       z1 = z0 - ANG_TWO_PI;
    else if (z0 < -ANG_PI) z1 = z0 + ANG_TWO_PI;
    z2   = z1;
    neg0 = 1'b0;
    if (z1 > ANG_HALF_PI) begin
      z2   = z1 - ANG_PI;
      neg0 = 1'b1;
    end else if (z1 < -ANG_HALF_PI) begin
      z2   = z1 + ANG_PI;
      neg0 = 1'b1;
    end
  end

  logic signed [19:0] sx, sy;
  logic signed [20:0] xf, yf;
  assign sx = x_r >>> ctl.cstep;
  assign sy = y_r >>> ctl.cstep;
  assign xf = neg_r ? -21'(x_r) : 21'(x_r);
  assign yf = neg_r ? -21'(y_r) : 21'(y_r);

  // operand select for the shared multiply-accumulate
  logic signed [33:0] dv;
  logic signed [18:0] a_sel;
  logic signed [33:0] b_sel;
  assign dv    = 34'(vtx_r[ctl.v][ctl.k]) - 34'(cent_r[ctl.k]) + 34'(off_r[ctl.k]);
  assign a_sel = ctl.mat_mode ? amat(axis_r, s_r, c_r, ctl.i, ctl.k)
                              : 19'(rot_r[ctl.i][ctl.k]);
  assign b_sel = ctl.mat_mode ? 34'(rot_r[ctl.k][ctl.j]) : dv;

  logic signed [52:0] prod;
  logic signed [55:0] acc_rnd;
  logic signed [39:0] rnd;
  logic signed [31:0] vert_val;
  assign prod     = a_r * b_r;
  assign acc_rnd  = acc_r + 56'sd32768;
  assign rnd      = acc_rnd[55:16];
  assign vert_val = sat32(41'(rnd) + 41'(cent_r[ctl.i]));

  // centroid of the stored vertices, truncated toward zero
  logic signed [31:0] cent_new [3];
  always_comb begin
    logic signed [33:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum = '0;
      for (int n = 0; n < VCOUNT; n++) sum = sum + 34'(vtx_r[n][k]);
      if (sum < 0) sum = sum + 34'(VCOUNT - 1);
      sum = sum >>> VCOUNT_LOG2;
      cent_new[k] = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      axis_r <= in_axis;
      idx_r  <= in_vertex_index;
      px_r   <= in_x;
      py_r   <= in_y;
      pz_r   <= in_z;
      amt_r  <= in_amount;
      ang_r  <= in_angle;
    end
    if (ctl.cordic_init) begin
      x_r   <= CORDIC_GAIN;
      y_r   <= '0;
      z_r   <= z2;
      neg_r <= neg0;
    end else if (ctl.cordic_step) begin
      if (z_r >= 0) begin
        x_r <= x_r - sy;
        y_r <= y_r + sx;
        z_r <= z_r - atan_val(ctl.cstep);
      end else begin
        x_r <= x_r + sy;
        y_r <= y_r - sx;
        z_r <= z_r + atan_val(ctl.cstep);
      end
    end
    if (ctl.cordic_fin) begin
      c_r <= clamp18(41'(xf));
      s_r <= clamp18(41'(yf));
    end
    if (ctl.mac_issue) begin
      a_r     <= a_sel;
      b_r     <= b_sel;
      first_r <= ctl.mac_first;
    end
    if (mac_v_r) acc_r <= (first_r ? 56'sd0 : acc_r) + 56'(prod);
    if (ctl.mat_wr) rnew_r[ctl.i][ctl.j] <= clamp18(41'(rnd));
    if (ctl.vert_wr) begin
      case (ctl.i)
        2'd0:    ox_r <= vert_val;
        2'd1:    oy_r <= vert_val;
        default: oz_r <= vert_val;
      endcase
      index_r <= ctl.v;
      last_r  <= (ctl.v == 2'(VCOUNT - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_v_r <= 1'b0;
      valid_r <= 1'b0;
      for (int n = 0; n < VCOUNT; n++)
        for (int k = 0; k < 3; k++) vtx_r[n][k] <= '0;
      for (int k = 0; k < 3; k++) begin
        cent_r[k] <= '0;
        off_r[k]  <= '0;
        for (int m = 0; m < 3; m++) rot_r[k][m] <= (k == m) ? MAT_ONE : 18'sd0;
      end
    end else begin
      mac_v_r <= ctl.mac_issue;
      valid_r <= ctl.vert_wr && (ctl.i == 2'd2);
      if (ctl.load_wr) begin
        vtx_r[idx_r][0] <= px_r;
        vtx_r[idx_r][1] <= py_r;
        vtx_r[idx_r][2] <= pz_r;
      end
      if (ctl.cent_upd) begin
        for (int k = 0; k < 3; k++) begin
          cent_r[k] <= cent_new[k];
          off_r[k]  <= '0;
          for (int m = 0; m < 3; m++) rot_r[k][m] <= (k == m) ? MAT_ONE : 18'sd0;
        end
      end
      if (ctl.shift_upd && axis_r != AXIS_NONE) begin
        off_r[axis_r]  <= sat32(41'(off_r[axis_r]) + 41'(amt_r));
        cent_r[axis_r] <= sat32(41'(cent_r[axis_r]) + 41'(amt_r));
      end
      if (ctl.mat_commit) begin
        for (int k = 0; k < 3; k++)
          for (int m = 0; m < 3; m++) rot_r[k][m] <= rnew_r[k][m];
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_index       = index_r;
  assign out_x           = ox_r;
  assign out_y           = oy_r;
  assign out_z           = oz_r;
  assign out_last_vertex = last_r;

endmodule

>>> rtl/core/pose_transform_four_vertex_unit.sv
// channel  | handshake          | payload
// ---------+--------------------+--------------------------------------------------
// input    | start / busy       | in_cmd in_axis in_vertex_index in_x in_y in_z
//          |                    | in_amount in_angle
// result   | out_valid (strobe) | out_index out_x out_y out_z out_last_vertex
//
// Load: capture, vertex write, centroid update; no result.
// Shift: four results from one shared MAC; no new command is accepted before the last result.
// Rotate: 16-step CORDIC, 9 matrix dot products, four vertices; axis none: vertices only.
// Synchronous active-low reset restores zero vertices, zero pose and identity rotation.
// Results are single-cycle strobes; the receiver cannot stall them.
`include "assert_macros.svh"

module pose_transform_four_vertex_unit
  import ptfv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic [1:0]         in_axis,
  input  logic [1:0]         in_vertex_index,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [31:0] in_amount,
  input  logic signed [15:0] in_angle,
  output logic               out_valid,
  output logic [1:0]         out_index,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_last_vertex
);

  ctl_t ctl;

  ptfv_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_cmd  (in_cmd),
    .in_axis (in_axis),
    .busy    (busy),
    .ctl     (ctl)
  );

  ptfv_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_axis         (in_axis),
    .in_vertex_index (in_vertex_index),
    .in_x            (in_x),
    .in_y            (in_y),
    .in_z            (in_z),
    .in_amount       (in_amount),
    .in_angle        (in_angle),
    .out_valid       (out_valid),
    .out_index       (out_index),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .out_last_vertex (out_last_vertex)
  );

  `CHK_NEXT(a_strobe_gap, clk, rst_n, out_valid, !out_valid, "result strobes back to back")
  `CHK_NEXT(a_busy_after_start, clk, rst_n, start && !busy && in_cmd != CMD_NONE, busy, "accepted item did not raise busy")
  `CHK_ALWAYS(a_last_idle, clk, rst_n, !(out_valid && out_last_vertex) || !busy, "last vertex while still busy")

endmodule
